// ===== src/iolm_pkg.sv =====
// ----------------------------------------------------------------------------
// I/O-wait load monitor package
// Shared widths, register indexes and types of the load monitor.
// ----------------------------------------------------------------------------
package iolm_pkg;

	// Shared divider: dividend, divisor and bit-count widths.
	localparam int DIV_W  = 52;
	localparam int DIV_DW = 32;
	localparam int DIV_NW = 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_FAST      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_SLOW      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ESTIMATOR_MODE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EWMA_WEIGHT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC  = 4'd7;

	// Command to the shared divider.
	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] nbits;
	} div_cmd_t;

endpackage

// ===== src/iolm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iolm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/iolm_div.sv =====
// ----------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider, one quotient bit per cycle. The caller places
// the dividend left-justified and gives the number of bits to develop.
// ----------------------------------------------------------------------------
module iolm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iolm_pkg::div_cmd_t            cmd,
	input  logic [iolm_pkg::DIV_W-1:0]    dividend,
	input  logic [iolm_pkg::DIV_DW-1:0]   divisor,
	output logic                          done,
	output logic [iolm_pkg::DIV_W-1:0]    quotient
);

	logic [iolm_pkg::DIV_DW-1:0] rem_q;
	logic [iolm_pkg::DIV_DW-1:0] dsr_q;
	logic [iolm_pkg::DIV_W-1:0]  dvd_q;
	logic [iolm_pkg::DIV_W-1:0]  quo_q;
	logic [iolm_pkg::DIV_NW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [iolm_pkg::DIV_DW:0]   trial;
	logic                        fits;

	// One trial subtraction a cycle.
	assign trial = {rem_q, dvd_q[iolm_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: count down the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == iolm_pkg::DIV_NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, shifted dividend and quotient.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? iolm_pkg::DIV_DW'(trial - {1'b0, dsr_q})
			              : trial[iolm_pkg::DIV_DW-1:0];
			dvd_q <= {dvd_q[iolm_pkg::DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[iolm_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/iowait_load_monitor.sv =====
// ----------------------------------------------------------------------------
// I/O-wait load monitor
// Wait rate, smoothed average, hysteresis alert and next poll interval.
// ----------------------------------------------------------------------------
// One poll is worked through by a sequencer around a shared bit-serial
// divider, so the block takes a new poll only after the previous one has
// finished. A poll works through up to four divisions of 42, 52, 24 and 25
// quotient bits, one bit a cycle; the EWMA path leaves out the 24-bit window
// division, and a poll with a zero time delta skips the second division. The
// first poll after reset only stores the baseline and gives no result.
// ----------------------------------------------------------------------------
module iowait_load_monitor #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iolm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iolm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Poll input.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       wait_ticks,
	input  logic [31:0]                       time_ms,
	// Result output.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       rate_permille,
	output logic [15:0]                       average_permille,
	output logic [12:0]                       average_percent,
	output logic                              alert_level,
	output logic                              alert_changed,
	output logic [11:0]                       next_poll_seconds
);

	localparam int PW   = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int SUMW = 16 + CW;
	localparam int NUMW = 25;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_DIV1 = 4'd2;
	localparam logic [3:0] ST_MUL2 = 4'd3;
	localparam logic [3:0] ST_DIV2 = 4'd4;
	localparam logic [3:0] ST_EST  = 4'd5;
	localparam logic [3:0] ST_WRD  = 4'd6;
	localparam logic [3:0] ST_WDS  = 4'd7;
	localparam logic [3:0] ST_WDIV = 4'd8;
	localparam logic [3:0] ST_EW0  = 4'd9;
	localparam logic [3:0] ST_EW1  = 4'd10;
	localparam logic [3:0] ST_EW2  = 4'd11;
	localparam logic [3:0] ST_EW3  = 4'd12;
	localparam logic [3:0] ST_PCT  = 4'd13;
	localparam logic [3:0] ST_ALR  = 4'd14;
	localparam logic [3:0] ST_INT  = 4'd15;

	// Configuration registers.
	logic [9:0]  thr_low_q, thr_high_q;
	logic [11:0] poll_fast_q, poll_slow_q;
	logic        mode_q;
	logic [6:0]  win_len_q;
	logic [15:0] weight_q;
	logic [13:0] tps_q;

	// Poll state.
	logic [3:0]      state_q;
	logic            base_valid_q;
	logic [31:0]     prev_ticks_q, prev_time_q;
	logic [31:0]     dticks_q, dt_q;
	logic [41:0]     ds_q;
	logic [15:0]     rate_q, avg_q;
	logic [12:0]     pct_q;
	logic [SUMW-1:0] sum_q;
	logic [PW-1:0]   pos_q, rpos_q;
	logic [CW-1:0]   count_q;
	logic            filled_q;
	logic [31:0]     ewma_q;
	logic [50:0]     acc_q;
	logic            alert_q;
	logic            alert_chg_q;
	logic            interp_q;
	logic            int_go_q;
	logic [11:0]     delay_q;
	logic [22:0]     prod1_q;
	logic signed [23:0] prod2_q;
	logic [9:0]      dlt_q;

	// Output registers.
	logic        out_valid_q;
	logic [15:0] o_rate_q, o_avg_q;
	logic [12:0] o_pct_q;
	logic        o_alert_q, o_chg_q;
	logic [11:0] o_next_q;

	// Divider and RAM connections.
	iolm_pkg::div_cmd_t          div_cmd;
	logic [iolm_pkg::DIV_W-1:0]  div_dvd;
	logic [iolm_pkg::DIV_DW-1:0] div_dsr;
	logic                        div_done;
	logic [iolm_pkg::DIV_W-1:0]  div_quo;
	logic                        ram_we;
	logic [15:0]                 ram_rdata;

	// Combinational helpers.
	logic [CW-1:0]   eff_len;
	logic [PW-1:0]   start_pos;
	logic [CW-1:0]   next_cnt;
	logic [SUMW-1:0] new_sum;
	logic [16:0]     mul_a;
	logic [15:0]     mul_b;
	logic [32:0]     mul_p;
	logic [31:0]     ewma_sat;
	logic [16:0]     ewma_rnd;
	logic [15:0]     ewma_avg;
	logic [31:0]     pct_prod;
	logic signed [25:0] num;
	logic [NUMW-1:0] num_pos;
	logic            alert_new;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != ST_IDLE;

	// Effective window length and the slot this poll writes.
	always_comb begin
		if (win_len_q == 7'd0) begin
			eff_len = CW'(1);
		end else if (32'(win_len_q) > WINDOW_DEPTH) begin
			eff_len = CW'(WINDOW_DEPTH);
		end else begin
			eff_len = CW'(win_len_q);
		end
		start_pos = (CW'(pos_q) >= eff_len) ? '0 : pos_q;
		next_cnt  = CW'(rpos_q) + 1'b1;
		new_sum   = sum_q - (filled_q ? SUMW'(ram_rdata) : '0) + SUMW'(rate_q);
	end

	// Shared multiplier for the EWMA update.
	always_comb begin
		unique case (state_q)
			ST_EW0: begin
				mul_a = {1'b0, weight_q};
				mul_b = rate_q;
			end
			ST_EW1: begin
				mul_a = 17'h10000 - {1'b0, weight_q};
				mul_b = ewma_q[15:0];
			end
			default: begin
				mul_a = 17'h10000 - {1'b0, weight_q};
				mul_b = ewma_q[31:16];
			end
		endcase
		mul_p = 33'(mul_a) * 33'(mul_b);
	end

	// EWMA accumulator saturation and rounding to the average.
	always_comb begin
		ewma_sat = (|acc_q[50:48]) ? 32'hFFFF_FFFF : acc_q[47:16];
		ewma_rnd = 17'((33'(ewma_sat) + 33'd32768) >> 16);
		ewma_avg = ewma_rnd[16] ? 16'hFFFF : ewma_rnd[15:0];
	end

	// Percent by reciprocal multiplication, exact for 16-bit averages.
	assign pct_prod = 32'(avg_q) * 32'd52429;

	// Hysteresis decision.
	always_comb begin
		alert_new = alert_q;
		if (alert_q) begin
			if (pct_q < 13'(thr_low_q)) begin
				alert_new = 1'b0;
			end
		end else if (pct_q >= 13'(thr_high_q)) begin
			alert_new = 1'b1;
		end
	end

	// Interpolation numerator, floored at zero.
	always_comb begin
		num = 26'(signed'({1'b0, prod1_q, 1'b0})) - 26'(prod2_q <<< 1)
		      + 26'(signed'({1'b0, dlt_q}));
		num_pos = num[25] ? '0 : num[NUMW-1:0];
	end

	// Divider command for each division.
	always_comb begin
		div_cmd = '0;
		div_dvd = '0;
		div_dsr = '0;
		unique case (state_q)
			ST_MUL1: begin
				div_cmd.start = 1'b1;
				div_cmd.nbits = iolm_pkg::DIV_NW'(42);
				div_dvd = {42'(dticks_q * 42'd1000), 10'd0};
				div_dsr = (tps_q == '0) ? 32'd1 : 32'(tps_q);
			end
			ST_MUL2: begin
				div_cmd.start = 1'b1;
				div_cmd.nbits = iolm_pkg::DIV_NW'(52);
				div_dvd = 52'(ds_q * 52'd1000);
				div_dsr = dt_q;
			end
			ST_WDS: begin
				div_cmd.start = 1'b1;
				div_cmd.nbits = iolm_pkg::DIV_NW'(SUMW + 1);
				div_dvd = iolm_pkg::DIV_W'({sum_q, 1'b0} + (SUMW + 1)'(count_q))
				          << (iolm_pkg::DIV_W - SUMW - 1);
				div_dsr = 32'({count_q, 1'b0});
			end
			ST_INT: begin
				// The interpolation division starts once, on the first cycle here.
				div_cmd.start = int_go_q;
				div_cmd.nbits = iolm_pkg::DIV_NW'(NUMW);
				div_dvd = {num_pos, 27'd0};
				div_dsr = 32'({dlt_q, 1'b0});
			end
			default: begin
				div_cmd = '0;
			end
		endcase
	end

	assign ram_we = state_q == ST_WRD;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q   <= 10'd0;
			thr_high_q  <= 10'd100;
			poll_fast_q <= 12'd1;
			poll_slow_q <= 12'd10;
			mode_q      <= 1'b0;
			win_len_q   <= 7'd8;
			weight_q    <= 16'd14564;
			tps_q       <= 14'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iolm_pkg::REG_THRESHOLD_LOW:  thr_low_q   <= cfg_data[9:0];
				iolm_pkg::REG_THRESHOLD_HIGH: thr_high_q  <= cfg_data[9:0];
				iolm_pkg::REG_POLL_FAST:      poll_fast_q <= cfg_data[11:0];
				iolm_pkg::REG_POLL_SLOW:      poll_slow_q <= cfg_data[11:0];
				iolm_pkg::REG_ESTIMATOR_MODE: mode_q      <= cfg_data[0];
				iolm_pkg::REG_WINDOW_LENGTH:  win_len_q   <= cfg_data[6:0];
				iolm_pkg::REG_EWMA_WEIGHT:    weight_q    <= cfg_data;
				iolm_pkg::REG_TICKS_PER_SEC:  tps_q       <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and its control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_valid_q <= 1'b0;
			prev_ticks_q <= '0;
			prev_time_q  <= '0;
			sum_q        <= '0;
			pos_q        <= '0;
			filled_q     <= 1'b0;
			ewma_q       <= '0;
			alert_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// A new window length restarts the window.
			if (cfg_valid && cfg_ready && cfg_index == iolm_pkg::REG_WINDOW_LENGTH) begin
				sum_q    <= '0;
				pos_q    <= '0;
				filled_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						base_valid_q <= 1'b1;
						prev_ticks_q <= wait_ticks;
						prev_time_q  <= time_ms;
						if (base_valid_q) begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (div_done) begin
						state_q <= (dt_q == '0) ? ST_EST : ST_MUL2;
					end
				end
				ST_MUL2: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_EST;
					end
				end
				ST_EST: state_q <= mode_q ? ST_EW0 : ST_WRD;
				ST_WRD: begin
					sum_q <= new_sum;
					if (next_cnt >= eff_len) begin
						filled_q <= 1'b1;
						pos_q    <= '0;
					end else begin
						pos_q <= PW'(next_cnt);
					end
					state_q <= ST_WDS;
				end
				ST_WDS: state_q <= ST_WDIV;
				ST_WDIV: begin
					if (div_done) begin
						state_q <= ST_PCT;
					end
				end
				ST_EW0: state_q <= ST_EW1;
				ST_EW1: state_q <= ST_EW2;
				ST_EW2: state_q <= ST_EW3;
				ST_EW3: begin
					ewma_q  <= ewma_sat;
					state_q <= ST_PCT;
				end
				ST_PCT: state_q <= ST_ALR;
				ST_ALR: begin
					alert_q <= alert_new;
					state_q <= ST_INT;
				end
				ST_INT: begin
					if (!interp_q || div_done) begin
						if (!out_valid_q || !out_stall) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of one poll.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dticks_q <= wait_ticks - prev_ticks_q;
				dt_q     <= time_ms - prev_time_q;
			end
			ST_DIV1: begin
				ds_q   <= div_quo[41:0];
				rate_q <= 16'hFFFF;
			end
			ST_DIV2: begin
				rate_q <= (|div_quo[51:16]) ? 16'hFFFF : div_quo[15:0];
			end
			ST_EST: begin
				rpos_q <= start_pos;
			end
			ST_WRD: begin
				count_q <= filled_q ? eff_len : next_cnt;
			end
			ST_WDIV: begin
				avg_q <= div_quo[15:0];
			end
			ST_EW0: acc_q <= 51'({mul_p, 16'd0}) + 51'd32768;
			ST_EW1: acc_q <= acc_q + 51'(mul_p);
			ST_EW2: acc_q <= acc_q + 51'({mul_p, 16'd0});
			ST_EW3: avg_q <= ewma_avg;
			ST_PCT: pct_q <= pct_prod[31:19];
			ST_ALR: begin
				alert_chg_q <= alert_new != alert_q;
				interp_q    <= 1'b0;
				int_go_q    <= 1'b0;
				if (pct_q <= 13'(thr_low_q)) begin
					delay_q <= poll_slow_q;
				end else if (pct_q >= 13'(thr_high_q)) begin
					delay_q <= poll_fast_q;
				end else begin
					interp_q <= 1'b1;
					int_go_q <= 1'b1;
				end
				dlt_q   <= thr_high_q - thr_low_q;
				prod1_q <= 23'(poll_slow_q) * 23'(10'(thr_high_q - thr_low_q));
				prod2_q <= 24'(signed'({1'b0, pct_q[9:0] - thr_low_q})
				           * (signed'({1'b0, poll_slow_q}) - signed'({1'b0, poll_fast_q})));
			end
			ST_INT: begin
				int_go_q <= 1'b0;
				if (interp_q && div_done) begin
					interp_q <= 1'b0;
					if (div_quo[NUMW-1:0] == '0) begin
						delay_q <= 12'd1;
					end else if (|div_quo[NUMW-1:12]) begin
						delay_q <= 12'hFFF;
					end else begin
						delay_q <= div_quo[11:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result register: loaded when the poll completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_INT && (!interp_q || div_done) && (!out_valid_q || !out_stall)) begin
			o_rate_q  <= rate_q;
			o_avg_q   <= avg_q;
			o_pct_q   <= pct_q;
			o_alert_q <= alert_q;
			o_chg_q   <= alert_chg_q;
			if (interp_q) begin
				if (div_quo[NUMW-1:0] == '0) begin
					o_next_q <= 12'd1;
				end else if (|div_quo[NUMW-1:12]) begin
					o_next_q <= 12'hFFF;
				end else begin
					o_next_q <= div_quo[11:0];
				end
			end else begin
				o_next_q <= (delay_q == '0) ? 12'd1 : delay_q;
			end
		end
	end

	iolm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	iolm_ram #(
		.WIDTH (16),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rpos_q),
		.wdata (rate_q),
		.raddr (start_pos),
		.rdata (ram_rdata)
	);

	assign out_valid         = out_valid_q;
	assign rate_permille     = o_rate_q;
	assign average_permille  = o_avg_q;
	assign average_percent   = o_pct_q;
	assign alert_level       = o_alert_q;
	assign alert_changed     = o_chg_q;
	assign next_poll_seconds = o_next_q;

endmodule

// ===== verif/iowait_load_monitor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I/O-wait load monitor testbench
// Drives polls and register writes into the load monitor and checks every
// result beat against a behavioral model of the rate, the smoothed average,
// the alert and the poll interval. A short directed poll table comes first,
// then corner settings, then random phases of several settings and idle mixes.
// ----------------------------------------------------------------------------
module iowait_load_monitor_tb;

	localparam int WIN_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_WAIT  = 400;
	localparam int PHASES      = 8;
	localparam int PHASE_POLLS = 200;

	// Register indexes past the end of the register list.
	localparam logic [iolm_pkg::CFG_IDX_W-1:0] REG_SPARE_NEAR = 4'd9;
	localparam logic [iolm_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = 4'd15;

	typedef struct packed {
		logic [15:0] rate;
		logic [15:0] avg;
		logic [12:0] pct;
		logic        level;
		logic        changed;
		logic [11:0] interval;
	} poll_result_t;

	typedef struct packed {
		logic [31:0]  ticks;
		logic [31:0]  stamp;
		logic         typed;
		poll_result_t res;
	} poll_row_t;

	localparam int DIR_ROWS = 12;

	// Directed polls under reset settings; typed results are read off by hand.
	poll_row_t dir_rows [DIR_ROWS] = '{
		'{32'd0,          32'd0,          1'b0, '0},
		'{32'd100,        32'd1000,       1'b1, '{16'd1000, 16'd1000, 13'd100, 1'b1, 1'b1, 12'd1}},
		'{32'd100,        32'd1000,       1'b1, '{16'd65535, 16'd33268, 13'd3326, 1'b1, 1'b0, 12'd1}},
		'{32'd100,        32'd2000,       1'b0, '0},
		'{32'hFFFF_FFFF,  32'd2001,       1'b0, '0},
		'{32'h0000_0010,  32'hFFFF_FFF0,  1'b0, '0},
		'{32'h0000_0020,  32'h0000_0100,  1'b0, '0},
		'{32'h0000_0025,  32'h0000_1100,  1'b0, '0},
		'{32'h0000_0025,  32'hFFFF_FFFF,  1'b0, '0},
		'{32'h0000_0026,  32'h0000_0000,  1'b0, '0},
		'{32'h0000_0030,  32'h0000_1000,  1'b0, '0},
		'{32'h0000_0031,  32'h0000_2000,  1'b0, '0}
	};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [iolm_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [iolm_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [31:0]                       wait_ticks = '0;
	logic [31:0]                       time_ms = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [15:0]                       rate_permille;
	logic [15:0]                       average_permille;
	logic [12:0]                       average_percent;
	logic                              alert_level;
	logic                              alert_changed;
	logic [11:0]                       next_poll_seconds;

	// Model registers.
	logic [9:0]  thr_low, thr_high;
	logic [11:0] poll_fast, poll_slow;
	logic        use_ewma;
	logic [6:0]  win_len;
	logic [15:0] ewma_alpha;
	logic [13:0] tick_rate;

	// Model state.
	logic        baseline_ok;
	logic [31:0] last_ticks, last_stamp;
	logic [15:0] win_mem [WIN_DEPTH];
	logic [31:0] win_sum;
	int unsigned win_pos;
	logic        win_full;
	logic [31:0] ewma_acc;
	logic        alert_now;

	poll_result_t expected_q [$];
	int          err_cnt = 0;
	int          cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	logic        hold_off = 1'b0;
	logic [31:0] cur_ticks, cur_stamp;

	iowait_load_monitor #(.WINDOW_DEPTH(WIN_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.wait_ticks(wait_ticks), .time_ms(time_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.rate_permille(rate_permille), .average_permille(average_permille),
		.average_percent(average_percent), .alert_level(alert_level),
		.alert_changed(alert_changed), .next_poll_seconds(next_poll_seconds)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		err_cnt++;
	endtask

	// Model of one poll: pushes the expected result when the poll makes one.
	task automatic model_poll(input logic [31:0] tk, input logic [31:0] tm);
		logic [31:0]     dtk, dtm;
		longint unsigned tps, scaled, rate, avg, pct, acc, sm;
		longint unsigned len, cnt, alpha;
		longint          slow, fast, num, den, span, delay;
		logic            was;
		poll_result_t    r;
		if (!baseline_ok) begin
			baseline_ok = 1'b1;
			last_ticks = tk;
			last_stamp = tm;
			return;
		end
		dtk = tk - last_ticks;
		dtm = tm - last_stamp;
		last_ticks = tk;
		last_stamp = tm;
		tps = (tick_rate == 0) ? 1 : tick_rate;
		scaled = longint'(dtk) * 1000 / tps;
		if (dtm == 0)
			rate = 65535;
		else
			rate = scaled * 1000 / longint'(dtm);
		if (rate > 65535)
			rate = 65535;
		// Only the selected estimator advances.
		if (use_ewma) begin
			alpha = ewma_alpha;
			acc = alpha * (rate << 16) + (65536 - alpha) * longint'(ewma_acc) + 32768;
			sm = acc >> 16;
			if (sm > 64'hFFFF_FFFF)
				sm = 64'hFFFF_FFFF;
			ewma_acc = sm[31:0];
			avg = (sm + 32768) >> 16;
		end else begin
			len = (win_len == 0) ? 1 : ((win_len > WIN_DEPTH) ? WIN_DEPTH : win_len);
			if (win_pos >= len)
				win_pos = 0;
			if (win_full)
				win_sum = win_sum - win_mem[win_pos];
			win_mem[win_pos] = rate[15:0];
			win_sum = win_sum + rate[31:0];
			win_pos++;
			cnt = win_full ? len : win_pos;
			if (win_pos >= len) begin
				win_full = 1'b1;
				win_pos = 0;
			end
			avg = (longint'(win_sum) * 2 + cnt) / (2 * cnt);
		end
		if (avg > 65535)
			avg = 65535;
		pct = avg * 100 / 1000;
		// Hysteresis on the percent value.
		was = alert_now;
		if (alert_now) begin
			if (pct < thr_low)
				alert_now = 1'b0;
		end else if (pct >= thr_high) begin
			alert_now = 1'b1;
		end
		// Next interval, interpolated between the thresholds.
		slow = poll_slow;
		fast = poll_fast;
		if (pct <= thr_low)
			delay = slow;
		else if (pct >= thr_high)
			delay = fast;
		else begin
			span = longint'(pct) - longint'(thr_low);
			den = longint'(thr_high) - longint'(thr_low);
			num = 2 * slow * den - 2 * span * (slow - fast) + den;
			if (num < 0)
				num = 0;
			delay = num / (2 * den);
		end
		if (delay < 1)
			delay = 1;
		if (delay > 4095)
			delay = 4095;
		r.rate = rate[15:0];
		r.avg = avg[15:0];
		r.pct = pct[12:0];
		r.level = alert_now;
		r.changed = alert_now ^ was;
		r.interval = delay[11:0];
		expected_q.push_back(r);
	endtask

	// Offer one poll beat and wait until it is taken.
	task automatic send_poll(input logic [31:0] tk, input logic [31:0] tm);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		wait_ticks <= tk;
		time_ms <= tm;
		do
			@(posedge clk);
		while (in_stall);
		model_poll(tk, tm);
	endtask

	// Let the block run dry before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [iolm_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			iolm_pkg::REG_THRESHOLD_LOW:  thr_low = val[9:0];
			iolm_pkg::REG_THRESHOLD_HIGH: thr_high = val[9:0];
			iolm_pkg::REG_POLL_FAST:      poll_fast = val[11:0];
			iolm_pkg::REG_POLL_SLOW:      poll_slow = val[11:0];
			iolm_pkg::REG_ESTIMATOR_MODE: use_ewma = val[0];
			iolm_pkg::REG_WINDOW_LENGTH: begin
				win_len = val[6:0];
				win_sum = '0;
				win_pos = 0;
				win_full = 1'b0;
			end
			iolm_pkg::REG_EWMA_WEIGHT:    ewma_alpha = val;
			iolm_pkg::REG_TICKS_PER_SEC:  tick_rate = val[13:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// One well-formed poll most of the time, a random one otherwise.
	task automatic random_poll();
		int unsigned dm, top;
		if ($urandom_range(9) == 0) begin
			cur_ticks = $urandom;
			cur_stamp = $urandom;
		end else begin
			dm = $urandom_range(20000, 0);
			top = dm * ((tick_rate == 0) ? 1 : tick_rate) / 1000 * 2 + 1;
			cur_stamp = cur_stamp + dm;
			cur_ticks = cur_ticks + $urandom_range(top, 0);
		end
		send_poll(cur_ticks, cur_stamp);
	endtask

	// Result checker and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("result beat with no expectation");
				end else begin
					poll_result_t e;
					e = expected_q.pop_front();
					if (rate_permille !== e.rate)
						report($sformatf("rate_permille %0d, expected %0d", rate_permille, e.rate));
					if (average_permille !== e.avg)
						report($sformatf("average_permille %0d, expected %0d",
							average_permille, e.avg));
					if (average_percent !== e.pct)
						report($sformatf("average_percent %0d, expected %0d",
							average_percent, e.pct));
					if (alert_level !== e.level)
						report($sformatf("alert_level %0b, expected %0b", alert_level, e.level));
					if (alert_changed !== e.changed)
						report($sformatf("alert_changed %0b, expected %0b",
							alert_changed, e.changed));
					if (next_poll_seconds !== e.interval)
						report($sformatf("next_poll_seconds %0d, expected %0d",
							next_poll_seconds, e.interval));
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < recv_idle);
		end
	end

	// Main sequence.
	initial begin
		logic [9:0] lo, hi;
		thr_low = 0; thr_high = 100; poll_fast = 1; poll_slow = 10;
		use_ewma = 0; win_len = 8; ewma_alpha = 16'd14564; tick_rate = 100;
		baseline_ok = 0; last_ticks = 0; last_stamp = 0;
		foreach (win_mem[i]) win_mem[i] = '0;
		win_sum = 0; win_pos = 0; win_full = 0; ewma_acc = 0; alert_now = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under reset settings.
		foreach (dir_rows[i]) begin
			send_poll(dir_rows[i].ticks, dir_rows[i].stamp);
			if (dir_rows[i].typed && expected_q[$] !== dir_rows[i].res)
				report($sformatf("directed row %0d disagrees with the typed result", i));
		end
		cur_ticks = dir_rows[DIR_ROWS-1].ticks;
		cur_stamp = dir_rows[DIR_ROWS-1].stamp;
		drain();

		// Corner settings: zero tick rate, zero and oversized window, crossed
		// thresholds, fast above slow, two indexes beyond the register list and extreme EWMA weights.
		write_reg(iolm_pkg::REG_TICKS_PER_SEC, 16'd0);
		write_reg(iolm_pkg::REG_WINDOW_LENGTH, 16'd0);
		write_reg(iolm_pkg::REG_THRESHOLD_LOW, 16'd900);
		write_reg(iolm_pkg::REG_THRESHOLD_HIGH, 16'd5);
		write_reg(REG_SPARE_NEAR, 16'hFFFF);
		write_reg(REG_SPARE_LAST, 16'h1234);
		repeat (4) random_poll();
		drain();
		write_reg(iolm_pkg::REG_WINDOW_LENGTH, 16'd127);
		write_reg(iolm_pkg::REG_THRESHOLD_LOW, 16'd10);
		write_reg(iolm_pkg::REG_THRESHOLD_HIGH, 16'd1000);
		write_reg(iolm_pkg::REG_POLL_FAST, 16'd3600);
		write_reg(iolm_pkg::REG_POLL_SLOW, 16'd1);
		write_reg(iolm_pkg::REG_TICKS_PER_SEC, 16'd10000);
		write_reg(iolm_pkg::REG_ESTIMATOR_MODE, 16'd1);
		write_reg(iolm_pkg::REG_EWMA_WEIGHT, 16'd65535);
		repeat (4) random_poll();
		drain();
		write_reg(iolm_pkg::REG_EWMA_WEIGHT, 16'd1);
		repeat (4) random_poll();
		drain();

		// Random phases, each with its own settings and idle mix.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 60; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 60; end
				default: begin send_idle = 35; recv_idle = 35; end
			endcase
			lo = (ph == 1) ? 10'd0 : ((ph == 2) ? 10'd1000 : 10'($urandom_range(300, 0)));
			hi = (ph == 1) ? 10'd1000 :
				((ph == 2) ? 10'd0 : 10'(lo + 10'($urandom_range(400, 1))));
			write_reg(iolm_pkg::REG_THRESHOLD_LOW, 16'(lo));
			write_reg(iolm_pkg::REG_THRESHOLD_HIGH, 16'(hi));
			write_reg(iolm_pkg::REG_POLL_FAST,
				(ph == 3) ? 16'd3600 : 16'($urandom_range(60, 1)));
			write_reg(iolm_pkg::REG_POLL_SLOW,
				(ph == 4) ? 16'd3600 : 16'($urandom_range(3600, 1)));
			write_reg(iolm_pkg::REG_ESTIMATOR_MODE, 16'(ph % 2));
			write_reg(iolm_pkg::REG_WINDOW_LENGTH,
				(ph == 5) ? 16'd64 : 16'($urandom_range(16, 1)));
			write_reg(iolm_pkg::REG_EWMA_WEIGHT,
				(ph == 6) ? 16'd65535 : 16'($urandom_range(65535, 1)));
			write_reg(iolm_pkg::REG_TICKS_PER_SEC,
				(ph == 7) ? 16'd1 : 16'($urandom_range(10000, 1)));
			if (ph == 2) begin
				// Long receiver hold-off while polls keep coming.
				fork
					begin
						hold_off = 1'b1;
						repeat (3000) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < PHASE_POLLS; n++)
				random_poll();
			drain();
		end

		while (hold_off)
			@(posedge clk);
		if (err_cnt == 0 && expected_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (expected_q.size() != 0)
				report("expectations left over at the end");
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
